// ===== rtl/core/sha256_byte_stream_hasher_top_assert.svh =====
// Assertion macros for the hasher top level.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// Check that a condition implies a result on the same edge.
`define SHA_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Check that a condition implies a result on the next edge.
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/core/sha_pkg.sv =====
package sha_pkg;

    localparam int QDepth = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } back_stat_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
        rotr = (x >> s) | (x << (6'd32 - {1'b0, s}));
    endfunction

endpackage

// ===== rtl/core/sha_front.sv =====
module sha_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  sha_pkg::item_t  in_item,
    output logic            q_valid,
    output sha_pkg::item_t  q_item,
    input  logic            q_take
);

    // drop items that carry neither a byte nor a last mark
    sha_pkg::item_t mem_reg [sha_pkg::QDepth];
    logic wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic wr;

    assign full = (cnt_reg == 2'(sha_pkg::QDepth));
    assign wr = push && !full && (in_item.has_byte || in_item.last);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr ? !wptr_reg : wptr_reg;
        rptr_next = q_take ? !rptr_reg : rptr_reg;
        cnt_next = cnt_reg + {1'b0, wr} - {1'b0, q_take};
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/sha_back.sv =====
module sha_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sha_pkg::item_t      q_item,
    output logic                q_take,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word,
    output sha_pkg::back_stat_t stat
);

    sha_pkg::state_t state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [60:0] cnt_reg;
    logic [6:0]  rnd_reg;
    logic        fin_reg;      // finishing the message
    logic        second_reg;   // padding needs a second block
    logic        pad_reg;      // first padding block already built
    logic [31:0] out_word_reg;
    logic [2:0]  out_idx_reg;
    logic        out_valid_reg;
    logic [2:0]  emit_reg;

    logic [5:0]  pos;
    logic [31:0] wcur, w2, w7, w15, w16, s0, s1, t1, t2, wnew;
    logic [31:0] a, e;
    logic        out_free;

    assign pos = cnt_reg[5:0];
    assign out_free = !out_valid_reg || pop;
    assign empty = !out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index = out_idx_reg;
    assign last_word = (out_idx_reg == 3'd7);
    assign stat.busy = (state_reg != sha_pkg::ST_IDLE);
    assign stat.out_full = out_valid_reg;

    always_comb
    begin
        w2 = w_reg[4'(rnd_reg - 7'd2)];
        w7 = w_reg[4'(rnd_reg - 7'd7)];
        w15 = w_reg[4'(rnd_reg - 7'd15)];
        w16 = w_reg[rnd_reg[3:0]];
        s1 = sha_pkg::rotr(w2, 5'd17) ^ sha_pkg::rotr(w2, 5'd19) ^ (w2 >> 10);
        s0 = sha_pkg::rotr(w15, 5'd7) ^ sha_pkg::rotr(w15, 5'd18) ^ (w15 >> 3);
        wnew = s1 + w7 + s0 + w16;
        wcur = (rnd_reg < 7'd16) ? w16 : wnew;
        a = v_reg[0];
        e = v_reg[4];
        t1 = v_reg[7] + (sha_pkg::rotr(e, 5'd6) ^ sha_pkg::rotr(e, 5'd11)
            ^ sha_pkg::rotr(e, 5'd25)) + ((e & v_reg[5]) ^ (~e & v_reg[6]))
            + sha_pkg::ROUND_K[rnd_reg[5:0]] + wcur;
        t2 = (sha_pkg::rotr(a, 5'd2) ^ sha_pkg::rotr(a, 5'd13) ^ sha_pkg::rotr(a, 5'd22))
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.has_byte && pos == 6'd63)
                    begin
                        state_next = sha_pkg::ST_ROUND;
                    end
                    else if (q_item.last)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (rnd_reg == 7'd63)
                begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD:
            begin
                if (!fin_reg)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
                else if (!pad_reg || second_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_EMIT;
                end
            end
            sha_pkg::ST_PAD:
            begin
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_EMIT:
            begin
                if (out_free && emit_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_take = (state_reg == sha_pkg::ST_IDLE) && q_valid;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.has_byte)
                    begin
                        unique case (pos[1:0])
                            2'd0: w_reg[pos[5:2]][31:24] <= q_item.data_byte;
                            2'd1: w_reg[pos[5:2]][23:16] <= q_item.data_byte;
                            2'd2: w_reg[pos[5:2]][15:8] <= q_item.data_byte;
                            default: w_reg[pos[5:2]][7:0] <= q_item.data_byte;
                        endcase
                    end
                    if (q_item.has_byte && pos == 6'd63)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                    end
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (rnd_reg >= 7'd16)
                begin
                    w_reg[rnd_reg[3:0]] <= wnew;
                end
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            sha_pkg::ST_PAD:
            begin
                // build the whole padded block in one step from the byte count
                for (int i = 0; i < 64; i++)
                begin
                    if (!second_reg && 6'(i) == pos)
                    begin
                        w_reg[i / 4][8 * (3 - i % 4) +: 8] <= 8'h80;
                    end
                    else if (second_reg || 6'(i) > pos)
                    begin
                        if (i >= 56 && (second_reg || pos < 6'd56))
                        begin
                            w_reg[i / 4][8 * (3 - i % 4) +: 8] <=
                                8'({cnt_reg, 3'b000} >> (8 * (63 - i)));
                        end
                        else
                        begin
                            w_reg[i / 4][8 * (3 - i % 4) +: 8] <= 8'h00;
                        end
                    end
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            default:
            begin
            end
        endcase
        if (out_free && state_reg == sha_pkg::ST_EMIT)
        begin
            out_word_reg <= h_reg[emit_reg];
            out_idx_reg <= emit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::H_INIT[i];
            end
            cnt_reg <= '0;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            second_reg <= 1'b0;
            pad_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            emit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sha_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        fin_reg <= q_item.last;
                        second_reg <= 1'b0;
                        pad_reg <= 1'b0;
                        if (q_item.has_byte)
                        begin
                            cnt_reg <= cnt_reg + 61'd1;
                        end
                        rnd_reg <= '0;
                    end
                end
                sha_pkg::ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                end
                sha_pkg::ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    rnd_reg <= '0;
                    emit_reg <= '0;
                end
                sha_pkg::ST_PAD:
                begin
                    // first block of the pad: 0x80 leaves no room for the length
                    second_reg <= !second_reg && (pos >= 6'd56);
                    pad_reg <= 1'b1;
                    rnd_reg <= '0;
                end
                sha_pkg::ST_EMIT:
                begin
                    if (out_free)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::H_INIT[i];
                            end
                            cnt_reg <= '0;
                            rnd_reg <= '0;
                            fin_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher_top.sv =====
// SHA-256 over a byte stream. Push one beat per byte (has_byte) and mark the
// final beat with last; a beat with last and no byte closes the message, so an
// empty message works. A two-entry queue takes beats while the hashing engine
// is busy. The engine packs plain bytes while idle; every 64th byte runs the
// compression, the rounds and then a fold, on a single shared round unit, and
// no beat is taken until it is done. A last beat adds a pad step before each
// compression it needs, one (two when fewer than nine bytes remain in the
// block), then eight digest beats, word 0 first, each with word_index and
// with last_word on the final word. After the digest the engine is back at
// the initial hash and a zero length, ready for the next message.
`include "sha256_byte_stream_hasher_top_assert.svh"

module sha256_byte_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_pkg::item_t      in_item, q_item;
    logic                q_valid, q_take;
    sha_pkg::back_stat_t stat;

    assign in_item.data_byte = data_byte;
    assign in_item.has_byte = has_byte;
    assign in_item.last = last;

    // front: hold accepted beats until the engine takes them
    sha_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    // back: pack bytes, compress, pad and emit the digest
    sha_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .stat        (stat)
    );

    `SHA_ASSERT_IMPLIES(a_take_when_idle, q_take, q_valid && !stat.busy)
    `SHA_ASSERT_IMPLIES(a_empty_matches, !empty, stat.out_full)
    `SHA_ASSERT_NEXT(a_out_held, !empty && !pop, !empty && $stable(digest_word))

endmodule

// ===== sim/tb_sha256_byte_stream_hasher_top.sv =====
module tb_sha256_byte_stream_hasher_top;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_byte_stream_hasher_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .has_byte(has_byte), .last(last),
        .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );

    // Predictor state: running hash, block under construction, byte count.
    logic [31:0]  hash_state [8];
    logic [31:0]  msg_block [16];
    logic [60:0]  msg_len;

    sha_pkg::item_t pending_beats [$];
    digest_beat_t expected_digest [$];
    int           errors;
    bit           stim_done;
    bit           hold_pop;      // long receiver hold-off
    int           hold_cycles;
    bit           drain_wait;    // sender waits for every result
    bit           draining;
    int           gap_left;
    int           burst_left;
    int           stall_phase;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    // One 64-round compression of msg_block into hash_state.
    task automatic compress_block();
        logic [31:0] v [8];
        logic [31:0] w_win [16];
        logic [31:0] w, t1, t2, s0, s1;
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 16; i++) w_win[i] = msg_block[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                w = w_win[r];
            else
            begin
                s1 = ror32(w_win[(r-2)&15], 17) ^ ror32(w_win[(r-2)&15], 19)
                     ^ (w_win[(r-2)&15] >> 10);
                s0 = ror32(w_win[(r-15)&15], 7) ^ ror32(w_win[(r-15)&15], 18)
                     ^ (w_win[(r-15)&15] >> 3);
                w = s1 + w_win[(r-7)&15] + s0 + w_win[r&15];
                w_win[r&15] = w;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic place_byte(int pos, logic [7:0] b);
        msg_block[pos >> 2][31 - 8*(pos & 3) -: 8] = b;
    endtask

    // Advance the hash by one accepted beat; queue a digest on last.
    task automatic hash_beat(sha_pkg::item_t it);
        int pos;
        logic [63:0] bit_len;
        if (it.has_byte)
        begin
            pos = int'(msg_len[5:0]);
            place_byte(pos, it.data_byte);
            msg_len = msg_len + 61'd1;
            if (pos == 63) compress_block();
        end
        if (!it.last) return;
        pos = int'(msg_len[5:0]);
        place_byte(pos, 8'h80);
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                place_byte(pos, 8'h00);
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            place_byte(pos, 8'h00);
            pos++;
        end
        bit_len = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++) place_byte(56 + i, bit_len[63 - 8*i -: 8]);
        compress_block();
        for (int i = 0; i < 8; i++)
            expected_digest.push_back('{hash_state[i], 3'(i), i == 7});
        for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::H_INIT[i];
        msg_len = '0;
    endtask

    function automatic sha_pkg::item_t make_beat(logic [7:0] b, bit hb, bit lst);
        sha_pkg::item_t it;
        it.data_byte = b;
        it.has_byte  = hb;
        it.last      = lst;
        return it;
    endfunction

    // Queue a message of n bytes; optionally close with a byteless last beat.
    task automatic queue_message(int n, bit byteless_close);
        for (int i = 0; i < n; i++)
        begin
            // sprinkle ignored beats as noise
            if ($urandom_range(0, 15) == 0)
                pending_beats.push_back(make_beat(8'($urandom), 1'b0, 1'b0));
            pending_beats.push_back(make_beat(8'($urandom), 1'b1,
                                    !byteless_close && i == n - 1));
        end
        if (byteless_close || n == 0)
            pending_beats.push_back(make_beat(8'($urandom), 1'b0, 1'b1));
    endtask

    // Driver: bursts and gaps, plus a drain pause when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            data_byte  <= '0;
            has_byte   <= 1'b0;
            last       <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
            draining   <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                hash_beat(make_beat(data_byte, has_byte, last));
                void'(pending_beats.pop_front());
            end
            if (push && full)
            begin
                // hold the offered beat until it is taken
            end
            else if (draining)
            begin
                push <= 1'b0;
                if (expected_digest.size() == 0) draining <= 1'b0;
            end
            else if (push && last && drain_wait)
            begin
                push     <= 1'b0;
                draining <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                push     <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_beats.size() > 0)
            begin
                push      <= 1'b1;
                data_byte <= pending_beats[0].data_byte;
                has_byte  <= pending_beats[0].has_byte;
                last      <= pending_beats[0].last;
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= $urandom_range(0, 2) == 0 ? 0
                                  : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver stall pattern, with a long hold-off while hold_pop is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop         <= 1'b0;
            stall_phase <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 23;
            if (hold_pop && hold_cycles < 300)
            begin
                hold_cycles <= hold_cycles + 1;
                pop <= 1'b0;
            end
            else if (stall_phase < 8)
                pop <= 1'b1;
            else
                pop <= $urandom_range(0, 2) != 0;
        end
    end

    // Monitor: compare each popped digest beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_digest.size() == 0)
            begin
                $display("%0t: unexpected digest beat word=%h index=%0d last=%b",
                         $realtime, digest_word, word_index, last_word);
                errors++;
            end
            else
            begin
                automatic digest_beat_t e = expected_digest.pop_front();
                if (digest_word !== e.word)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $realtime, e.word, digest_word);
                    errors++;
                end
                if (word_index !== e.index)
                begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $realtime, e.index, word_index);
                    errors++;
                end
                if (last_word !== e.is_last)
                begin
                    $display("%0t: last_word expected %b actual %b",
                             $realtime, e.is_last, last_word);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors     = 0;
        stim_done  = 0;
        hold_pop   = 0;
        drain_wait = 0;
        msg_len    = '0;
        for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::H_INIT[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty messages, byte extremes, byteless and byte-carrying closes.
        queue_message(0, 1'b0);
        pending_beats.push_back(make_beat(8'h00, 1'b1, 1'b0));
        pending_beats.push_back(make_beat(8'hff, 1'b0, 1'b0));
        pending_beats.push_back(make_beat(8'hff, 1'b1, 1'b1));
        pending_beats.push_back(make_beat(8'h00, 1'b0, 1'b1));
        queue_message(3, 1'b1);
        queue_message(5, 1'b0);

        // Hold the receiver so the block backs up; sender keeps offering.
        hold_pop = 1;
        for (int m = 0; m < 6; m++) queue_message($urandom_range(0, 10), $urandom_range(0, 1));
        wait (pending_beats.size() == 0);
        hold_pop = 0;
        wait (expected_digest.size() == 0);

        // Random messages, lengths near block and padding edges half the time.
        while (pending_beats.size() < 260)
        begin
            automatic int pick = $urandom_range(0, 5);
            automatic int n = pick == 0 ? $urandom_range(55, 57)
                            : pick == 1 ? $urandom_range(63, 65)
                            : pick == 2 ? $urandom_range(119, 121)
                            : $urandom_range(0, 20);
            queue_message(n, $urandom_range(0, 3) == 0);
        end
        // Pause the sender after each last beat for a full drain.
        drain_wait = 1;
        wait (pending_beats.size() == 0);
        drain_wait = 0;
        queue_message(60, 1'b0);
        queue_message(1, 1'b0);
        wait (pending_beats.size() == 0 && !push);
        wait (expected_digest.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_digest.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
